FILE: src/dssq_pkg.sv
package dssq_pkg;

   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int COIL_W  = 4;
   localparam int DUTY_W  = 10;
   localparam int STEP_W  = 7;
   localparam int RATIO_W = 3;
   localparam int SPEED_W = 4;
   localparam int POS_W   = 2;

   // item kinds on the request channel
   typedef enum logic [MODE_W-1:0] {
      MODE_ADDR = 2'd0,
      MODE_DATA = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   // command frame capture
   typedef enum logic [2:0] {
      FRAME_FIRST  = 3'b001,
      FRAME_SECOND = 3'b010,
      FRAME_DONE   = 3'b100
   } frame_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [COIL_W-1:0] coils_a;
      logic [COIL_W-1:0] coils_b;
      logic              idle_flag;
      logic [DUTY_W-1:0] pwm_duty;
   } result_type;

   localparam logic [DUTY_W-1:0] DUTY_OFF  = 10'd0;
   localparam logic [DUTY_W-1:0] DUTY_MID  = 10'd1000;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1023;

   // coil pattern for a motor position
   function automatic logic [COIL_W-1:0] phase_pattern(input logic [POS_W-1:0] pos);
      logic [COIL_W-1:0] pat;
      case (pos)
         2'd0:    pat = 4'b0001;
         2'd1:    pat = 4'b0100;
         2'd2:    pat = 4'b0010;
         default: pat = 4'b1000;
      endcase
      return pat;
   endfunction

   // timer reload for a speed code
   function automatic logic [BYTE_W-1:0] speed_reload(input logic [SPEED_W-1:0] code);
      logic [BYTE_W-1:0] val;
      case (code)
         4'd0:    val = 8'd0;
         4'd1:    val = 8'd105;
         4'd2:    val = 8'd150;
         4'd3:    val = 8'd173;
         4'd4:    val = 8'd195;
         4'd5:    val = 8'd202;
         4'd6:    val = 8'd210;
         4'd7:    val = 8'd214;
         4'd8:    val = 8'd218;
         4'd9:    val = 8'd222;
         4'd10:   val = 8'd227;
         4'd11:   val = 8'd228;
         4'd12:   val = 8'd230;
         4'd13:   val = 8'd231;
         4'd14:   val = 8'd232;
         default: val = 8'd233;
      endcase
      return val;
   endfunction

   // PWM duty for a speed code
   function automatic logic [DUTY_W-1:0] speed_duty(input logic [SPEED_W-1:0] code);
      logic [DUTY_W-1:0] val;
      case (code)
         4'd0, 4'd1: val = DUTY_OFF;
         4'd2:       val = DUTY_MID;
         default:    val = DUTY_FULL;
      endcase
      return val;
   endfunction

endpackage

FILE: src/dssq_req_if.sv
interface dssq_req_if;
   import dssq_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

FILE: src/dssq_rsp_if.sv
interface dssq_rsp_if;
   import dssq_pkg::*;

   logic              valid;
   logic              ready;
   logic [COIL_W-1:0] coils_a;
   logic [COIL_W-1:0] coils_b;
   logic              idle_flag;
   logic [DUTY_W-1:0] pwm_duty;

   modport source (output valid, output coils_a, output coils_b, output idle_flag,
                   output pwm_duty, input ready);
   modport sink   (input valid, input coils_a, input coils_b, input idle_flag,
                   input pwm_duty, output ready);
endinterface

FILE: src/dssq_core.sv
module dssq_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  dssq_pkg::item_type   item,
   output dssq_pkg::result_type result
);
   import dssq_pkg::*;

   frame_type          frame_ff, frame_in;
   logic [BYTE_W-1:0]  first_ff, first_in;
   logic               master_a_ff, master_a_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               reverse_ff, reverse_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [RATIO_W-1:0] ratio_cnt_ff, ratio_cnt_in;
   logic [BYTE_W-1:0]  reload_ff, reload_in;
   logic [BYTE_W-1:0]  timer_ff, timer_in;
   logic               running_ff, running_in;
   logic [POS_W-1:0]   pos_a_ff, pos_a_in;
   logic [POS_W-1:0]   pos_b_ff, pos_b_in;
   logic [COIL_W-1:0]  drive_a_ff, drive_a_in;
   logic [COIL_W-1:0]  drive_b_ff, drive_b_in;
   logic               idle_ff, idle_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   logic [SPEED_W-1:0] speed;
   logic [BYTE_W-1:0]  timer_inc;
   logic [RATIO_W-1:0] ratio_dec;
   logic               move_a, move_b, back_a, back_b;

   assign speed     = item.data_byte[SPEED_W-1:0];
   assign timer_inc = timer_ff + 1'b1;
   assign ratio_dec = ratio_cnt_ff - 1'b1;

   // decide which motors move and which way on an overflow
   always_comb begin
      if (ratio_ff == '0) begin
         // pivot: master goes the commanded way, slave the other way
         move_a = 1'b1;
         move_b = 1'b1;
         back_a = master_a_ff ? reverse_ff : !reverse_ff;
         back_b = master_a_ff ? !reverse_ff : reverse_ff;
      end else begin
         move_a = master_a_ff || (ratio_dec == '0);
         move_b = !master_a_ff || (ratio_dec == '0);
         back_a = reverse_ff;
         back_b = reverse_ff;
      end
   end

   // next state for the item at the head of the pipe
   always_comb begin
      frame_in     = frame_ff;
      first_in     = first_ff;
      master_a_in  = master_a_ff;
      steps_in     = steps_ff;
      reverse_in   = reverse_ff;
      ratio_in     = ratio_ff;
      ratio_cnt_in = ratio_cnt_ff;
      reload_in    = reload_ff;
      timer_in     = timer_ff;
      running_in   = running_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      drive_a_in   = drive_a_ff;
      drive_b_in   = drive_b_ff;
      idle_in      = idle_ff;
      duty_in      = duty_ff;

      unique case (mode_type'(item.mode))
         MODE_ADDR: begin
            frame_in = FRAME_FIRST;
         end
         MODE_DATA: begin
            unique case (frame_ff)
               FRAME_FIRST: begin
                  first_in = item.data_byte;
                  frame_in = FRAME_SECOND;
               end
               FRAME_SECOND: begin
                  // second byte completes the command
                  frame_in     = FRAME_DONE;
                  master_a_in  = first_ff[BYTE_W-1];
                  steps_in     = first_ff[STEP_W-1:0];
                  reverse_in   = item.data_byte[BYTE_W-1];
                  ratio_in     = item.data_byte[SPEED_W +: RATIO_W];
                  ratio_cnt_in = item.data_byte[SPEED_W +: RATIO_W];
                  reload_in    = speed_reload(speed);
                  duty_in      = speed_duty(speed);
                  if (first_ff[STEP_W-1:0] != '0) begin
                     running_in = 1'b1;
                     idle_in    = 1'b0;
                     timer_in   = speed_reload(speed);
                  end else begin
                     // zero steps: stop and release the coils
                     running_in = 1'b0;
                     idle_in    = 1'b1;
                     drive_a_in = '0;
                     drive_b_in = '0;
                  end
               end
               default: begin
                  // frame complete: drop extra bytes
               end
            endcase
         end
         MODE_TICK: begin
            if (running_ff) begin
               if (timer_inc == '0) begin
                  timer_in = reload_ff;
                  if (ratio_ff != '0) begin
                     ratio_cnt_in = (ratio_dec == '0) ? ratio_ff : ratio_dec;
                  end
                  if (move_a) begin
                     pos_a_in   = back_a ? pos_a_ff - 1'b1 : pos_a_ff + 1'b1;
                     drive_a_in = phase_pattern(pos_a_in);
                  end
                  if (move_b) begin
                     pos_b_in   = back_b ? pos_b_ff - 1'b1 : pos_b_ff + 1'b1;
                     drive_b_in = phase_pattern(pos_b_in);
                  end
                  steps_in = steps_ff - 1'b1;
                  if (steps_in == '0) begin
                     running_in = 1'b0;
                     idle_in    = 1'b1;
                  end
               end else begin
                  timer_in = timer_inc;
               end
            end
         end
         default: begin
            // unused mode: hold
         end
      endcase
   end

   // update state once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= FRAME_FIRST;
         first_ff     <= '0;
         master_a_ff  <= 1'b0;
         steps_ff     <= '0;
         reverse_ff   <= 1'b0;
         ratio_ff     <= '0;
         ratio_cnt_ff <= '0;
         reload_ff    <= '0;
         timer_ff     <= '0;
         running_ff   <= 1'b0;
         pos_a_ff     <= '0;
         pos_b_ff     <= '0;
         drive_a_ff   <= '0;
         drive_b_ff   <= '0;
         idle_ff      <= 1'b1;
         duty_ff      <= '0;
      end else if (advance) begin
         frame_ff     <= frame_in;
         first_ff     <= first_in;
         master_a_ff  <= master_a_in;
         steps_ff     <= steps_in;
         reverse_ff   <= reverse_in;
         ratio_ff     <= ratio_in;
         ratio_cnt_ff <= ratio_cnt_in;
         reload_ff    <= reload_in;
         timer_ff     <= timer_in;
         running_ff   <= running_in;
         pos_a_ff     <= pos_a_in;
         pos_b_ff     <= pos_b_in;
         drive_a_ff   <= drive_a_in;
         drive_b_ff   <= drive_b_in;
         idle_ff      <= idle_in;
         duty_ff      <= duty_in;
      end
   end

   assign result.coils_a   = drive_a_ff;
   assign result.coils_b   = drive_b_ff;
   assign result.idle_flag = idle_ff;
   assign result.pwm_duty  = duty_ff;

   // idle is exactly the absence of motion
   a_idle_running: assert property (@(posedge clock) disable iff (reset)
      idle_ff == !running_ff)
      else $error("idle flag disagrees with run state");

   // motion always has steps left to take
   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (steps_ff != '0))
      else $error("running with zero steps left");

   // at most one coil energized per motor
   a_coils_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(drive_a_ff) && $onehot0(drive_b_ff))
      else $error("more than one coil driven");

   // slave divider stays within one to the ratio
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      (ratio_ff != '0) |-> (ratio_cnt_ff != '0) && (ratio_cnt_ff <= ratio_ff))
      else $error("ratio counter out of range");

   // state holds between items
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(timer_ff) && $stable(steps_ff) && $stable(pos_a_ff))
      else $error("state changed without an item");
endmodule

FILE: src/dual_stepper_motion_sequencer_top.sv
// Dual stepper motion sequencer. Each request beat is an address byte, a
// data byte or one prescaled timer tick; every beat yields exactly one
// response beat carrying both motors' coil drive, the idle flag and the PWM
// duty as they stand after that beat. Two data bytes after an address byte
// form a motion command (master, step count, direction, turn ratio, speed
// code); ticks run an 8-bit timer; each overflow steps the master, and the slave as the ratio allows.
// The block takes one beat per clock: a request register feeds the update
// logic, and the motion state registers themselves form the response
// register, so the response to a beat passes through the request register
// and then the motion state registers before it reaches the response port,
// and a new beat is taken every cycle as long as responses drain.
module dual_stepper_motion_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   dssq_req_if.sink   req_ch,
   dssq_rsp_if.source rsp_ch
);
   import dssq_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_take;
   result_type result;

   // move the held beat into the state when the response slot frees up
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture the request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode      <= req_ch.mode;
         in_item_ff.data_byte <= req_ch.data_byte;
      end
   end

   dssq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.coils_a   = result.coils_a;
   assign rsp_ch.coils_b   = result.coils_b;
   assign rsp_ch.idle_flag = result.idle_flag;
   assign rsp_ch.pwm_duty  = result.pwm_duty;
endmodule

FILE: bench/dual_stepper_motion_sequencer_top_tb.sv
`timescale 1ns / 1ps

module dual_stepper_motion_sequencer_top_tb;
   import dssq_pkg::*;

   // mode 3 carries no event
   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

   // motor step directions
   localparam logic [1:0] DIR_HOLD = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BACK = 2'd2;

   // speed code to timer reload, code 15 in the top byte
   localparam logic [16*BYTE_W-1:0] RELOAD_TABLE = {
      8'd233, 8'd232, 8'd231, 8'd230, 8'd228, 8'd227, 8'd222, 8'd218,
      8'd214, 8'd210, 8'd202, 8'd195, 8'd173, 8'd150, 8'd105, 8'd0
   };
   // coil pattern by position, position 3 in the top nibble
   localparam logic [4*COIL_W-1:0] PHASE_TABLE = {4'd8, 4'd2, 4'd4, 4'd1};

   localparam int RAND_BEATS    = 1050;
   localparam int HOLD_AT_BEAT  = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_HEAVY} stall_style_type;

   typedef struct packed {
      logic       typed;
      result_type want;
   } out_note_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] data;
      logic              typed;
      result_type        want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dssq_req_if req_if ();
   dssq_rsp_if rsp_if ();

   dual_stepper_motion_sequencer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   // model state
   frame_type         frame_pos;
   logic [BYTE_W-1:0] first_byte;
   logic              master_is_a;
   logic [STEP_W-1:0] steps_left;
   logic              reverse_dir;
   logic [RATIO_W-1:0] turn_ratio;
   logic [RATIO_W-1:0] ratio_left;
   logic [BYTE_W-1:0] reload_value;
   logic [BYTE_W-1:0] timer_count;
   logic              running;
   logic [POS_W-1:0]  pos_a, pos_b;
   logic [COIL_W-1:0] drive_a, drive_b;
   logic              idle_reg;
   logic [DUTY_W-1:0] duty_reg;

   out_note_type beat_notes[$];
   result_type   pending_outputs[$];
   dir_row_type  directed_rows[$];

   int  fail_count  = 0;
   int  beats_sent  = 0;
   int  burst_left  = 0;
   bit  hold_active = 1'b0;

   // move one motor a phase and load its coil pattern
   task automatic step_motor(inout logic [POS_W-1:0] pos, inout logic [COIL_W-1:0] drive,
                             input logic [1:0] dir);
      if (dir == DIR_FWD) pos = pos + 2'd1;
      else if (dir == DIR_BACK) pos = pos - 2'd1;
      if (dir == DIR_FWD || dir == DIR_BACK) drive = PHASE_TABLE[{pos, 2'b00} +: COIL_W];
   endtask

   // advance the motion state by one beat and return the outputs after it
   task automatic update_motion(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] bus_byte,
                                output result_type out);
      logic [1:0] fwd, back, slave, dir_a, dir_b;
      if (mode == MODE_ADDR) begin
         frame_pos = FRAME_FIRST;
      end else if (mode == MODE_DATA) begin
         if (frame_pos == FRAME_FIRST) begin
            first_byte = bus_byte;
            frame_pos  = FRAME_SECOND;
         end else if (frame_pos == FRAME_SECOND) begin
            // decode the command
            frame_pos    = FRAME_DONE;
            master_is_a  = first_byte[7];
            steps_left   = first_byte[6:0];
            reverse_dir  = bus_byte[7];
            turn_ratio   = bus_byte[6:4];
            ratio_left   = bus_byte[6:4];
            reload_value = RELOAD_TABLE[{bus_byte[3:0], 3'b000} +: BYTE_W];
            if (bus_byte[3:0] <= 4'd1) duty_reg = DUTY_OFF;
            else if (bus_byte[3:0] == 4'd2) duty_reg = DUTY_MID;
            else duty_reg = DUTY_FULL;
            if (steps_left != '0) begin
               running     = 1'b1;
               idle_reg    = 1'b0;
               timer_count = reload_value;
            end else begin
               running  = 1'b0;
               idle_reg = 1'b1;
               drive_a  = '0;
               drive_b  = '0;
            end
         end
      end else if (mode == MODE_TICK && running) begin
         timer_count = timer_count + 8'd1;
         if (timer_count == '0) begin
            // overflow: step the master, and the slave as the ratio allows
            timer_count = reload_value;
            fwd  = reverse_dir ? DIR_BACK : DIR_FWD;
            back = reverse_dir ? DIR_FWD : DIR_BACK;
            if (turn_ratio == '0) begin
               dir_a = master_is_a ? fwd : back;
               dir_b = master_is_a ? back : fwd;
            end else begin
               slave      = DIR_HOLD;
               ratio_left = ratio_left - 3'd1;
               if (ratio_left == '0) begin
                  slave      = fwd;
                  ratio_left = turn_ratio;
               end
               dir_a = master_is_a ? fwd : slave;
               dir_b = master_is_a ? slave : fwd;
            end
            step_motor(pos_a, drive_a, dir_a);
            step_motor(pos_b, drive_b, dir_b);
            steps_left = steps_left - 7'd1;
            if (steps_left == '0) begin
               running  = 1'b0;
               idle_reg = 1'b1;
            end
         end
      end
      out = {drive_a, drive_b, idle_reg, duty_reg};
   endtask

   task automatic add_row(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                          input logic typed, input logic [COIL_W-1:0] ca,
                          input logic [COIL_W-1:0] cb, input logic idle,
                          input logic [DUTY_W-1:0] duty);
      directed_rows.push_back({mode, data, typed, ca, cb, idle, duty});
   endtask

   // offer one beat, with burst gaps, and hold it until taken
   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                            input logic typed, input result_type want);
      int unsigned gap;
      gap = 0;
      if (!hold_active) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         burst_left--;
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat_notes.push_back({typed, want});
      req_if.valid     <= 1'b1;
      req_if.mode      <= mode;
      req_if.data_byte <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_rand(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data);
      send_beat(mode, data, 1'b0, '0);
   endtask

   // predict on every accepted request beat
   always @(posedge clock) begin : req_monitor
      out_note_type note;
      result_type   predicted;
      if (!reset && req_if.valid && req_if.ready) begin
         note = beat_notes.pop_front();
         update_motion(req_if.mode, req_if.data_byte, predicted);
         pending_outputs.push_back(note.typed ? note.want : predicted);
      end
   end

   // compare every accepted response beat with the oldest prediction
   always @(posedge clock) begin : rsp_checker
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outputs.size() == 0) begin
            $error("response beat with no outstanding request");
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_if.coils_a !== want.coils_a) begin
               $error("coils_a: expected %0d, got %0d", want.coils_a, rsp_if.coils_a);
               fail_count++;
            end
            if (rsp_if.coils_b !== want.coils_b) begin
               $error("coils_b: expected %0d, got %0d", want.coils_b, rsp_if.coils_b);
               fail_count++;
            end
            if (rsp_if.idle_flag !== want.idle_flag) begin
               $error("idle_flag: expected %0d, got %0d", want.idle_flag, rsp_if.idle_flag);
               fail_count++;
            end
            if (rsp_if.pwm_duty !== want.pwm_duty) begin
               $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, rsp_if.pwm_duty);
               fail_count++;
            end
         end
      end
   end

   // response side: stall on its own pattern, with one long hold-off
   initial begin : rsp_staller
      stall_style_type style;
      int unsigned     span;
      bit              held;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && beats_sent >= HOLD_AT_BEAT) begin
            held        = 1'b1;
            hold_active = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         style = stall_style_type'($urandom_range(0, 3));
         span  = $urandom_range(5, 40);
         for (int i = 0; i < span; i++) begin
            case (style)
               STALL_NONE: begin
                  rsp_if.ready <= 1'b1;
               end
               STALL_COIN: begin
                  rsp_if.ready <= 1'($urandom_range(0, 1));
               end
               STALL_EVERY4: begin
                  rsp_if.ready <= (i % 4 != 3);
               end
               default: begin
                  rsp_if.ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int unsigned       pick, ticks, count, rand_start;
      logic [STEP_W-1:0] steps;
      logic [SPEED_W-1:0] speed;
      logic [BYTE_W-1:0] reload;
      logic [MODE_W-1:0] mode;
      req_if.valid     = 1'b0;
      req_if.mode      = MODE_ADDR;
      req_if.data_byte = '0;

      // idle ticks, dead mode, frames before any address, zero-step commands
      add_row(MODE_TICK, 8'h00, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_NOP,  8'hFF, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_DATA, 8'h00, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_DATA, 8'h00, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_DATA, 8'hFF, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_ADDR, 8'hFF, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_DATA, 8'h80, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_OFF);
      add_row(MODE_DATA, 8'h02, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_MID);
      // longest run, master B, reverse, widest ratio, fastest speed
      add_row(MODE_ADDR, 8'h00, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'h7F, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'hFF, 1'b1, 4'd0, 4'd0, 1'b0, DUTY_FULL);
      repeat (5) add_row(MODE_TICK, 8'hA5, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_NOP,  8'h55, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      // replace the running command, then release with a zero-step one
      add_row(MODE_ADDR, 8'h12, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'h81, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'h01, 1'b1, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_TICK, 8'h5A, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_ADDR, 8'h34, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'h00, 1'b0, 4'd0, 4'd0, 1'b0, DUTY_OFF);
      add_row(MODE_DATA, 8'h73, 1'b1, 4'd0, 4'd0, 1'b1, DUTY_FULL);

      // reset the model and the block together
      frame_pos    = FRAME_FIRST;
      first_byte   = '0;
      master_is_a  = 1'b0;
      steps_left   = '0;
      reverse_dir  = 1'b0;
      turn_ratio   = '0;
      ratio_left   = '0;
      reload_value = '0;
      timer_count  = '0;
      running      = 1'b0;
      pos_a        = '0;
      pos_b        = '0;
      drive_a      = '0;
      drive_b      = '0;
      idle_reg     = 1'b1;
      duty_reg     = DUTY_OFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].want);

      rand_start = beats_sent;
      while (beats_sent - rand_start < RAND_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // well-formed command followed by ticks, often enough to run it out
            pick = $urandom_range(0, 19);
            if (pick < 2) steps = '0;
            else if (pick < 3) steps = 7'($urandom_range(0, 127));
            else if (pick < 6) steps = 7'($urandom_range(5, 9));
            else steps = 7'($urandom_range(1, 4));
            speed  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(12, 15));
            reload = RELOAD_TABLE[{speed, 3'b000} +: BYTE_W];
            send_rand(MODE_ADDR, 8'($urandom_range(0, 255)));
            send_rand(MODE_DATA, {1'($urandom_range(0, 1)), steps});
            send_rand(MODE_DATA, {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), speed});
            if (steps == '0) ticks = $urandom_range(0, 4);
            else ticks = steps * (256 - reload) + $urandom_range(0, 6);
            if (ticks > 320) ticks = 320;
            if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
            repeat (ticks) begin
               // stray data bytes and dead beats between ticks
               if ($urandom_range(0, 19) == 0)
                  send_rand(($urandom_range(0, 1) != 0) ? MODE_DATA : MODE_NOP,
                            8'($urandom_range(0, 255)));
               send_rand(MODE_TICK, 8'($urandom_range(0, 255)));
            end
         end else if (pick < 85) begin
            // broken frame: address and one data byte, then restart, ticks or dead beats
            send_rand(MODE_ADDR, 8'($urandom_range(0, 255)));
            send_rand(MODE_DATA, 8'($urandom_range(0, 255)));
            count = $urandom_range(1, 4);
            repeat (count) begin
               pick = $urandom_range(0, 2);
               mode = (pick == 0) ? MODE_ADDR : (pick == 1) ? MODE_TICK : MODE_NOP;
               send_rand(mode, 8'($urandom_range(0, 255)));
            end
         end else begin
            // plain noise over all modes
            count = $urandom_range(1, 8);
            repeat (count) send_rand(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end
      req_if.valid <= 1'b0;

      // drain, then allow for stray beats
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("FAILURE");
      $finish;
   end

endmodule
